@@ sv/telemetry_frame_serializer_macros.svh @@
// Assertion macros used by the telemetry frame serializer top level.
`ifndef TELEMETRY_FRAME_SERIALIZER_MACROS_SVH
`define TELEMETRY_FRAME_SERIALIZER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TFS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/tfs_pkg.sv @@
// Types and constants shared by the telemetry frame serializer modules.
`timescale 1ns / 1ps

package tfs_pkg;

   localparam int WORD_COUNT   = 11;
   localparam int RECORD_BYTES = WORD_COUNT * 4 + 1;
   localparam int RECORD_BITS  = RECORD_BYTES * 8;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [5:0] DEVICE_POS = 6'd4;
   localparam logic [5:0] COUNT_POS  = 6'd5;
   localparam logic [5:0] WORD_POS   = 6'd6;
   localparam logic [5:0] STATUS_POS = 6'd50;
   localparam logic [5:0] SUM_POS    = 6'd51;
   localparam logic [5:0] CR_POS     = 6'd52;
   localparam logic [5:0] LAST_POS   = 6'd53;

   localparam logic [7:0] SYNC_BYTE       = 8'hFF;
   localparam logic [7:0] TAG_T_BYTE      = 8'h54;
   localparam logic [7:0] TAG_R_BYTE      = 8'h52;
   localparam logic [7:0] CR_BYTE         = 8'h0D;
   localparam logic [7:0] LF_BYTE         = 8'h0A;
   localparam logic [7:0] DEVICE_ID_RESET = 8'h01;

   typedef logic [RECORD_BITS-1:0] tfs_record_type;
   typedef logic [5:0]             tfs_index_type;

   typedef struct packed {
      logic [31:0] baro_altitude;
      logic [31:0] gps_altitude;
      logic [31:0] gps_latitude;
      logic [31:0] gps_longitude;
      logic [31:0] accel_x;
      logic [31:0] accel_y;
      logic [31:0] accel_z;
      logic [31:0] rate_x;
      logic [31:0] rate_y;
      logic [31:0] rate_z;
      logic [31:0] roll_angle;
      logic [7:0]  status_code;
   } tfs_req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_last;
   } tfs_rsp_type;

   typedef struct packed {
      logic       busy;
      logic [7:0] frame_count;
   } tfs_back_status_type;

   function automatic logic [7:0] header_byte(input logic [1:0] pos);
      logic [7:0] value;
      unique case (pos)
         2'd0:    value = SYNC_BYTE;
         2'd1:    value = SYNC_BYTE;
         2'd2:    value = TAG_T_BYTE;
         default: value = TAG_R_BYTE;
      endcase
      return value;
   endfunction

endpackage

@@ sv/tfs_front.sv @@
// Front end: accepts requests, packs them into byte order and queues them.
`timescale 1ns / 1ps

module tfs_front
   import tfs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  tfs_req_type    req_payload,
   output logic           q_valid,
   output tfs_record_type q_record,
   input  logic           q_pop
);

   tfs_record_type entry_ff [QUEUE_DEPTH];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           push;
   tfs_record_type packed_record;

   // Byte 0 of the record is the low byte of the first word; status is last.
   always_comb begin
      packed_record = {req_payload.status_code,
                       req_payload.roll_angle,
                       req_payload.rate_z,
                       req_payload.rate_y,
                       req_payload.rate_x,
                       req_payload.accel_z,
                       req_payload.accel_y,
                       req_payload.accel_x,
                       req_payload.gps_longitude,
                       req_payload.gps_latitude,
                       req_payload.gps_altitude,
                       req_payload.baro_altitude};
   end

   assign req_stall = (count_ff == 2'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_record  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= packed_record;
      end
   end

endmodule

@@ sv/tfs_back.sv @@
// Back end: walks a queued record through the 54-byte frame, one byte a cycle unless stalled.
`timescale 1ns / 1ps

module tfs_back
   import tfs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  tfs_record_type      q_record,
   output logic                q_pop,
   input  logic [7:0]          device_id,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output tfs_rsp_type         rsp_payload,
   output tfs_back_status_type status
);

   logic           busy_ff, busy_in;
   tfs_index_type  idx_ff, idx_in;
   tfs_record_type shreg_ff, shreg_in;
   logic [7:0]     sum_ff, sum_in;
   logic [7:0]     count_ff, count_in;
   logic           rsp_valid_ff, rsp_valid_in;
   tfs_rsp_type    rsp_ff, rsp_in;
   logic           out_ready;
   logic           emit;
   logic           last;
   logic           load;
   logic           in_body;
   logic [7:0]     cur_byte;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign emit      = busy_ff && out_ready;
   assign last      = (idx_ff == LAST_POS);
   assign load      = q_valid && (!busy_ff || (emit && last));
   assign q_pop     = load;
   assign in_body   = (idx_ff >= WORD_POS) && (idx_ff <= STATUS_POS);

   always_comb begin
      priority if (idx_ff < DEVICE_POS) begin
         cur_byte = header_byte(idx_ff[1:0]);
      end else if (idx_ff == DEVICE_POS) begin
         cur_byte = device_id;
      end else if (idx_ff == COUNT_POS) begin
         cur_byte = count_ff;
      end else if (in_body) begin
         cur_byte = shreg_ff[7:0];
      end else if (idx_ff == SUM_POS) begin
         cur_byte = sum_ff;
      end else if (idx_ff == CR_POS) begin
         cur_byte = CR_BYTE;
      end else begin
         cur_byte = LF_BYTE;
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      shreg_in     = shreg_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (emit) begin
         idx_in = idx_ff + 6'd1;
         // Checksum runs from the device id through the status byte.
         if (idx_ff == DEVICE_POS) begin
            sum_in = cur_byte;
         end else if ((idx_ff == COUNT_POS) || in_body) begin
            sum_in = sum_ff + cur_byte;
         end
         if (in_body) begin
            shreg_in = shreg_ff >> 8;
         end
         if (last) begin
            busy_in  = 1'b0;
            count_in = count_ff + 8'd1;
         end
      end
      if (load) begin
         busy_in  = 1'b1;
         idx_in   = '0;
         shreg_in = q_record;
      end
      if (out_ready) begin
         rsp_valid_in      = emit;
         rsp_in.frame_byte = cur_byte;
         rsp_in.frame_last = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         count_ff     <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shreg_ff <= shreg_in;
      sum_ff   <= sum_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload        = rsp_ff;
   assign status.busy        = busy_ff;
   assign status.frame_count = count_ff;

endmodule

@@ sv/telemetry_frame_serializer.sv @@
// Telemetry frame serializer top level: register port, front queue and frame back end.
// Each request carries one telemetry record (eleven 32-bit words and a status byte)
// on req_payload; it is accepted on a clock edge with req_valid high and req_stall low.
// For every request the block sends a 54-byte frame on rsp_payload, one byte per
// accepted response: FF FF 54 52, device id, frame counter, the eleven words low
// byte first, the status byte, an 8-bit sum of bytes 4 through 50, then 0D 0A.
// frame_last marks the final 0A byte.
// A request taken by an idle block passes through the queue entry, the back end's index
// register and the output register before its first byte reaches rsp_valid. The back
// end emits one byte per cycle while rsp_stall is low; a queued frame follows the 0A
// byte with no gap. A two-entry request queue lets the sender run ahead by two records.
// While rsp_valid is high, rsp_stall holds the byte in the output register and freezes
// the back end; requests still enter until the queue is full, then req_stall rises.
// The device id register is written through csr_valid/csr_data (csr_ready is always
// high) and should only change while no frame is pending.
// Synchronous reset empties the queue, drops any frame in progress, clears the frame
// counter to 0 and sets the device id to 1.
`timescale 1ns / 1ps
`include "telemetry_frame_serializer_macros.svh"

module telemetry_frame_serializer
   import tfs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  tfs_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output tfs_rsp_type rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   logic [7:0]          device_id_ff, device_id_in;
   logic                q_valid;
   tfs_record_type      q_record;
   logic                q_pop;
   tfs_back_status_type back_status;
   logic                rsp_take;

   assign csr_ready    = 1'b1;
   assign device_id_in = (csr_valid && csr_ready) ? csr_data : device_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_id_ff <= DEVICE_ID_RESET;
      end else begin
         device_id_ff <= device_id_in;
      end
   end

   tfs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_valid     (q_valid),
      .q_record    (q_record),
      .q_pop       (q_pop)
   );

   tfs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_record    (q_record),
      .q_pop       (q_pop),
      .device_id   (device_id_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .status      (back_status)
   );

   assign rsp_take = rsp_valid && !rsp_stall;

   `TFS_ASSERT_IMPLIES(a_last_is_lf, clock, reset, rsp_valid && rsp_payload.frame_last, rsp_payload.frame_byte == LF_BYTE, "frame_last set on a byte other than LF")
   `TFS_ASSERT_IMPLIES(a_count_advances, clock, reset, back_status.frame_count != $past(back_status.frame_count), rsp_valid && rsp_payload.frame_last && back_status.frame_count == $past(back_status.frame_count) + 8'd1, "frame counter moved other than by one at a frame end")
   `TFS_ASSERT_NEXT(a_frame_no_gap, clock, reset, rsp_take && !rsp_payload.frame_last, rsp_valid && (back_status.busy || rsp_payload.frame_last), "gap inside a frame")

endmodule

@@ bench/telemetry_frame_serializer_checker.sv @@
// Scoreboard for the telemetry frame serializer: builds expected frames and checks each byte.
`timescale 1ns / 1ps

module telemetry_frame_serializer_checker
   import tfs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  tfs_req_type req_payload,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  tfs_rsp_type rsp_payload,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_data,
   output int          mismatch_count,
   output int          bytes_pending
);

   localparam int FRAME_BYTES = 54;

   tfs_rsp_type frame_bytes_due[$];
   logic [7:0]  device_id_copy;
   logic [7:0]  frame_counter;
   int          byte_position;

   // Expand one record into the 54 bytes the block must send for it.
   function automatic void predict_frame(input tfs_req_type rec);
      logic [31:0] words [WORD_COUNT];
      logic [7:0]  frame [FRAME_BYTES];
      logic [7:0]  sum;
      tfs_rsp_type entry;
      words[0]  = rec.baro_altitude;
      words[1]  = rec.gps_altitude;
      words[2]  = rec.gps_latitude;
      words[3]  = rec.gps_longitude;
      words[4]  = rec.accel_x;
      words[5]  = rec.accel_y;
      words[6]  = rec.accel_z;
      words[7]  = rec.rate_x;
      words[8]  = rec.rate_y;
      words[9]  = rec.rate_z;
      words[10] = rec.roll_angle;
      frame[0] = SYNC_BYTE;
      frame[1] = SYNC_BYTE;
      frame[2] = TAG_T_BYTE;
      frame[3] = TAG_R_BYTE;
      frame[4] = device_id_copy;
      frame[5] = frame_counter;
      for (int w = 0; w < WORD_COUNT; w++) begin
         for (int b = 0; b < 4; b++) begin
            frame[6 + 4 * w + b] = words[w][8 * b +: 8];
         end
      end
      frame[50] = rec.status_code;
      sum = 8'h00;
      for (int k = 4; k <= 50; k++) begin
         sum += frame[k];
      end
      frame[51] = sum;
      frame[52] = CR_BYTE;
      frame[53] = LF_BYTE;
      for (int k = 0; k < FRAME_BYTES; k++) begin
         entry.frame_byte = frame[k];
         entry.frame_last = (k == FRAME_BYTES - 1);
         frame_bytes_due.push_back(entry);
      end
      frame_counter = frame_counter + 8'd1;
   endfunction

   function automatic void report(input string what);
      mismatch_count++;
      $display("%0t: %s", $time, what);
   endfunction

   always @(posedge clock) begin
      tfs_rsp_type due;
      if (reset) begin
         frame_bytes_due.delete();
         device_id_copy = DEVICE_ID_RESET;
         frame_counter  = 8'h00;
         byte_position  = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            device_id_copy = csr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (frame_bytes_due.size() == 0) begin
               report($sformatf("unexpected frame byte %02h last %0b",
                                rsp_payload.frame_byte, rsp_payload.frame_last));
            end else begin
               due = frame_bytes_due.pop_front();
               if (rsp_payload.frame_byte !== due.frame_byte) begin
                  report($sformatf("frame byte %0d: expected %02h, actual %02h",
                                   byte_position, due.frame_byte, rsp_payload.frame_byte));
               end
               if (rsp_payload.frame_last !== due.frame_last) begin
                  report($sformatf("frame_last at byte %0d: expected %0b, actual %0b",
                                   byte_position, due.frame_last, rsp_payload.frame_last));
               end
               byte_position = due.frame_last ? 0 : byte_position + 1;
            end
         end
         if (req_valid && !req_stall) begin
            predict_frame(req_payload);
         end
      end
      bytes_pending = frame_bytes_due.size();
   end

endmodule

@@ bench/telemetry_frame_serializer_test.sv @@
// Top of the telemetry frame serializer testbench: clock, reset, requests and verdict.
`timescale 1ns / 1ps

module telemetry_frame_serializer_test;
   import tfs_pkg::*;

   localparam int IDLE_LIMIT    = 1000;
   localparam int PHASE_RECORDS = 88;
   localparam int RANDOM_PHASES = 5;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   tfs_req_type req_payload;
   logic        rsp_valid;
   logic        rsp_stall;
   tfs_rsp_type rsp_payload;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_data;
   int          mismatch_count;
   int          bytes_pending;
   int          idle_cycles;
   bit          req_steady;
   bit          rsp_steady;

   always #2 clock = ~clock;

   telemetry_frame_serializer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   telemetry_frame_serializer_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .bytes_pending  (bytes_pending)
   );

   function automatic tfs_req_type fill_record(input logic [31:0] word,
                                               input logic [7:0] status);
      tfs_req_type rec;
      rec = {{WORD_COUNT{word}}, status};
      return rec;
   endfunction

   // Each byte differs: values count up from the first word's high byte, so any reordering shows.
   function automatic tfs_req_type ascending_record();
      tfs_req_type rec;
      logic [7:0]  b;
      b = 8'd1;
      for (int k = RECORD_BYTES - 1; k >= 1; k--) begin
         rec[8 * k +: 8] = b;
         b = b + 8'd1;
      end
      rec[7:0] = 8'h2D;
      return rec;
   endfunction

   // Mostly random words, with all-zero and all-one words mixed in.
   function automatic tfs_req_type random_record();
      tfs_req_type rec;
      int          pick;
      for (int k = 0; k < WORD_COUNT; k++) begin
         pick = $urandom_range(0, 9);
         rec[8 + 32 * k +: 32] = (pick == 0) ? 32'h0000_0000 :
                                 (pick == 1) ? 32'hFFFF_FFFF : 32'($urandom);
      end
      rec[7:0] = 8'($urandom_range(0, 255));
      return rec;
   endfunction

   task automatic send_record(input tfs_req_type rec);
      int gap;
      gap = req_steady ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= rec;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drain every frame in flight, then write the register on an idle block.
   task automatic write_device_id(input logic [7:0] id);
      req_valid <= 1'b0;
      @(posedge clock);
      while (bytes_pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= id;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Receiver: unless rsp_steady is set, hold off each byte for a random number of cycles.
   initial begin
      int gap;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = rsp_steady ? 0 : $urandom_range(0, 7);
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_valid   <= 1'b0;
      csr_data    <= 8'h00;
      req_steady  = 1'b0;
      rsp_steady  = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed records with the reset device id.
      send_record(fill_record(32'h0000_0000, 8'h00));
      send_record(fill_record(32'hFFFF_FFFF, 8'hFF));
      send_record(fill_record(32'hAAAA_AAAA, 8'h55));
      send_record(fill_record(32'h5555_5555, 8'hAA));
      send_record(ascending_record());
      send_record(fill_record(32'h8000_0000, 8'h80));
      send_record(fill_record(32'h0000_0001, 8'h01));
      send_record(random_record());

      write_device_id(8'h00);
      send_record(fill_record(32'h0000_0000, 8'h00));
      send_record(fill_record(32'hFFFF_FFFF, 8'hFF));

      // Largest id with all-one data drives the checksum through many wraps.
      write_device_id(8'hFF);
      send_record(fill_record(32'hFFFF_FFFF, 8'hFF));
      send_record(fill_record(32'h0000_0000, 8'h00));
      send_record(ascending_record());

      // Random phases; the frame counter wraps past 255 along the way.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_device_id((p == 2) ? 8'h80 : 8'($urandom_range(0, 255)));
         for (int n = 0; n < PHASE_RECORDS; n++) begin
            if (n % 30 == 0) begin
               req_steady = ($urandom_range(0, 3) == 0);
               rsp_steady = ($urandom_range(0, 3) == 0);
            end
            send_record(random_record());
         end
      end

      req_valid <= 1'b0;
      while (bytes_pending != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (mismatch_count == 0 && bytes_pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
